/* rtl/sfh_pkg.sv */
// sfh_pkg: shared types, codes and mixing functions for the hash stream block
// used by sfh_front, sfh_queue, sfh_back and the top level; no dependencies
`default_nettype none

package sfh_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned VbW     = 3;
    localparam int unsigned LenW    = 31;
    localparam int unsigned HashW   = 32;
    // packed input fields: word, valid_bytes, total_length, seed
    localparam int unsigned InFieldW = WordW + VbW + LenW + HashW;
    localparam int unsigned InDataW  = ((InFieldW + 7) / 8) * 8;

    localparam logic [VbW-1:0] VbFull = 3'd4;
    localparam logic [VbW-1:0] VbTail3 = 3'd3;
    localparam logic [VbW-1:0] VbTail2 = 3'd2;
    localparam logic [VbW-1:0] VbTail1 = 3'd1;
    localparam logic [VbW-1:0] VbNone = 3'd0;

    // what the back end does with one item
    typedef enum logic [2:0] {
        KIND_ROUND = 3'd0,  // not last: one mixing round into the running hash
        KIND_FULL  = 3'd1,  // last with four bytes
        KIND_T3    = 3'd2,  // last with three bytes
        KIND_T2    = 3'd3,  // last with two bytes
        KIND_T1    = 3'd4,  // last with one byte
        KIND_NONE  = 3'd5,  // last with no bytes, avalanche only
        KIND_EMPTY = 3'd6   // empty message, result is zero
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               load;   // take start value instead of running hash
        logic [HashW-1:0]   start;
        logic [WordW-1:0]   word;
    } cmd_t;

    function automatic logic [HashW-1:0] sext_byte(input logic [7:0] b);
        return {{(HashW-8){b[7]}}, b};
    endfunction

    function automatic logic [HashW-1:0] full_round(input logic [HashW-1:0] h_in,
                                                    input logic [WordW-1:0] w);
        logic [HashW-1:0] h;
        logic [HashW-1:0] t;
        h = h_in + {16'd0, w[15:0]};
        t = ({16'd0, w[31:16]} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic logic [HashW-1:0] tail3(input logic [HashW-1:0] h_in,
                                               input logic [WordW-1:0] w);
        logic [HashW-1:0] h;
        h = h_in + {16'd0, w[15:0]};
        h = h ^ (h << 16);
        h = h ^ (sext_byte(w[23:16]) << 18);
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic logic [HashW-1:0] tail2(input logic [HashW-1:0] h_in,
                                               input logic [WordW-1:0] w);
        logic [HashW-1:0] h;
        h = h_in + {16'd0, w[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
        return h;
    endfunction

    function automatic logic [HashW-1:0] tail1(input logic [HashW-1:0] h_in,
                                               input logic [WordW-1:0] w);
        logic [HashW-1:0] h;
        h = h_in + sext_byte(w[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 1);
        return h;
    endfunction

    // first three avalanche steps
    function automatic logic [HashW-1:0] aval_lo(input logic [HashW-1:0] h_in);
        logic [HashW-1:0] h;
        h = h_in ^ (h_in << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        return h;
    endfunction

    // last three avalanche steps
    function automatic logic [HashW-1:0] aval_hi(input logic [HashW-1:0] h_in);
        logic [HashW-1:0] h;
        h = h_in + (h_in >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

endpackage

`default_nettype wire

/* rtl/sfh_front.sv */
// sfh_front: classifies an incoming item into a back-end command
// depends on sfh_pkg for the command type and valid byte codes
`default_nettype none

module sfh_front (
    input  wire logic [sfh_pkg::WordW-1:0]  word,
    input  wire logic [sfh_pkg::VbW-1:0]    valid_bytes,
    input  wire logic                       first,
    input  wire logic                       last,
    input  wire logic [sfh_pkg::LenW-1:0]   total_length,
    input  wire logic [sfh_pkg::HashW-1:0]  seed,
    output sfh_pkg::cmd_t                   cmd
);

    sfh_pkg::kind_t kind;

    // pick the round or tail case
    always_comb begin
        if (!last) begin
            kind = sfh_pkg::KIND_ROUND;
        end else begin
            case (valid_bytes)
                sfh_pkg::VbNone:  kind = first ? sfh_pkg::KIND_EMPTY : sfh_pkg::KIND_NONE;
                sfh_pkg::VbTail1: kind = sfh_pkg::KIND_T1;
                sfh_pkg::VbTail2: kind = sfh_pkg::KIND_T2;
                sfh_pkg::VbTail3: kind = sfh_pkg::KIND_T3;
                default:          kind = sfh_pkg::KIND_FULL;  // four or more bytes
            endcase
        end
    end

    // start value: seed when nonzero, else the length
    always_comb begin
        cmd.kind  = kind;
        cmd.load  = first;
        cmd.start = (seed != '0) ? seed : {1'b0, total_length};
        cmd.word  = word;
    end

endmodule

`default_nettype wire

/* rtl/sfh_queue.sv */
// sfh_queue: small command queue between the front and back ends
// depends on sfh_pkg for the command type
`default_nettype none

module sfh_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire sfh_pkg::cmd_t push_cmd,
    output logic        full,
    input  wire logic   pop,
    output sfh_pkg::cmd_t pop_cmd,
    output logic        empty
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    sfh_pkg::cmd_t      mem_reg [DEPTH];
    logic [PtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]    count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CntW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/sfh_back.sv */
// sfh_back: running hash, tail step, two avalanche stages and output register
// depends on sfh_pkg for the command type and mixing functions
`default_nettype none

module sfh_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire sfh_pkg::cmd_t              cmd,
    input  wire logic                       cmd_valid,
    output logic                            cmd_pop,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [sfh_pkg::HashW-1:0]       m_hash
);

    logic [sfh_pkg::HashW-1:0] run_reg, run_next;
    logic [sfh_pkg::HashW-1:0] tail_reg, tail_next;
    logic [sfh_pkg::HashW-1:0] av_reg;
    logic [sfh_pkg::HashW-1:0] out_reg;
    logic                      tail_v_reg, av_v_reg, out_v_reg;
    logic [sfh_pkg::HashW-1:0] h0;
    logic                      is_round;
    logic                      out_free, av_free, tail_free;
    logic                      tail_load;

    // stage handshakes, back to front
    assign out_free  = !out_v_reg || m_ready;
    assign av_free   = !av_v_reg || out_free;
    assign tail_free = !tail_v_reg || av_free;

    assign is_round  = (cmd.kind == sfh_pkg::KIND_ROUND);
    assign cmd_pop   = cmd_valid && (is_round || tail_free);
    assign tail_load = cmd_pop && !is_round;

    assign h0 = cmd.load ? cmd.start : run_reg;

    // mixing round or tail case
    always_comb begin
        run_next  = run_reg;
        tail_next = h0;
        case (cmd.kind)
            sfh_pkg::KIND_FULL:  tail_next = sfh_pkg::full_round(h0, cmd.word);
            sfh_pkg::KIND_T3:    tail_next = sfh_pkg::tail3(h0, cmd.word);
            sfh_pkg::KIND_T2:    tail_next = sfh_pkg::tail2(h0, cmd.word);
            sfh_pkg::KIND_T1:    tail_next = sfh_pkg::tail1(h0, cmd.word);
            sfh_pkg::KIND_EMPTY: tail_next = '0;
            default:             tail_next = h0;
        endcase
        if (cmd_pop) begin
            run_next = is_round ? sfh_pkg::full_round(h0, cmd.word) : '0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg    <= '0;
            tail_v_reg <= 1'b0;
            av_v_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            run_reg <= run_next;
            if (tail_free) begin
                tail_v_reg <= tail_load;
            end
            if (av_free) begin
                av_v_reg <= tail_v_reg;
            end
            if (out_free) begin
                out_v_reg <= av_v_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (tail_load) begin
            tail_reg <= tail_next;
        end
        if (av_free && tail_v_reg) begin
            av_reg <= sfh_pkg::aval_lo(tail_reg);
        end
        if (out_free && av_v_reg) begin
            out_reg <= sfh_pkg::aval_hi(av_reg);
        end
    end

    assign m_valid = out_v_reg;
    assign m_hash  = out_reg;

endmodule

`default_nettype wire

/* rtl/superfasthash_stream.sv */
// superfasthash_stream: 32-bit hash over a stream of little-endian words
// path: a last item goes through the command queue, the tail step register
// and two avalanche stages, the second of which is the output register;
// throughput one item per cycle while neither the queue nor the output
// stalls, set by the mixing round on the running hash register
// reset: synchronous active-low aresetn empties the queue and all stages and
// clears the running hash; no clearing pass
`default_nettype none

module superfasthash_stream #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // word[31:0], valid_bytes[34:32], total_length[65:35], seed[97:66], zero pad
    input  wire logic [sfh_pkg::InDataW-1:0]    s_tdata,
    // first
    input  wire logic                           s_tuser,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // hash[31:0]
    output logic [sfh_pkg::HashW-1:0]           m_tdata
);

    localparam int unsigned VbLo   = sfh_pkg::WordW;
    localparam int unsigned LenLo  = VbLo + sfh_pkg::VbW;
    localparam int unsigned SeedLo = LenLo + sfh_pkg::LenW;

    sfh_pkg::cmd_t front_cmd;
    sfh_pkg::cmd_t back_cmd;
    logic          q_full, q_empty, q_pop;

    // classify the incoming item
    sfh_front u_front (
        .word         (s_tdata[sfh_pkg::WordW-1:0]),
        .valid_bytes  (s_tdata[LenLo-1:VbLo]),
        .first        (s_tuser),
        .last         (s_tlast),
        .total_length (s_tdata[SeedLo-1:LenLo]),
        .seed         (s_tdata[SeedLo+sfh_pkg::HashW-1:SeedLo]),
        .cmd          (front_cmd)
    );

    assign s_tready = !q_full;

    // command queue
    sfh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_tvalid),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (back_cmd),
        .empty    (q_empty)
    );

    // hash engine
    sfh_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (back_cmd),
        .cmd_valid (!q_empty),
        .cmd_pop   (q_pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_hash    (m_tdata)
    );

endmodule

`default_nettype wire

/* rtl/sfh_checker.sv */
// sfh_checker: port-level checks for superfasthash_stream, bound to the top
// depends on sfh_pkg for port widths
`default_nettype none

module sfh_checker (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    input  wire logic                       s_tready,
    input  wire logic                       s_tlast,
    input  wire logic                       m_tvalid,
    input  wire logic                       m_tready,
    input  wire logic [sfh_pkg::HashW-1:0]  m_tdata
);

    logic [7:0] pending_reg, pending_next;
    logic       in_last, out_take;

    assign in_last  = s_tvalid && s_tready && s_tlast;
    assign out_take = m_tvalid && m_tready;

    // last items still owed a result
    always_comb begin
        pending_next = pending_reg;
        if (in_last && !out_take) begin
            pending_next = pending_reg + 1'b1;
        end else if (!in_last && out_take) begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // a stalled result stays valid
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // reset leaves no result and an open input
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear the block");

    // every result belongs to a last item
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 8'd0)
        else $error("result without a last item");

endmodule

bind superfasthash_stream sfh_checker u_sfh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* sim/testbench.sv */
// testbench for superfasthash_stream: drives messages of little-endian words and
// checks every emitted hash against a cycle-free predictor kept in this file
// depends on sfh_pkg and superfasthash_stream from the rtl folder
`default_nettype none

module testbench;

    localparam int unsigned ITEM_COUNT     = 750;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned DRAIN_CYCLES   = 16;
    localparam int unsigned PadW           = sfh_pkg::InDataW - sfh_pkg::InFieldW;
    // counts above a full word, treated as a full word
    localparam logic [sfh_pkg::VbW-1:0] VbOverMin = 3'd5;
    localparam logic [sfh_pkg::VbW-1:0] VbOverMax = 3'd7;

    // layout of s_tdata, lowest field last
    typedef struct packed {
        logic [PadW-1:0]           pad;
        logic [sfh_pkg::HashW-1:0] seed;
        logic [sfh_pkg::LenW-1:0]  length;
        logic [sfh_pkg::VbW-1:0]   nbytes;
        logic [sfh_pkg::WordW-1:0] word;
    } stream_fields_t;

    typedef struct {
        stream_fields_t fields;
        bit             first;
        bit             last;
    } msg_item_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [sfh_pkg::InDataW-1:0]   s_tdata = '0;
    logic                          s_tuser = 1'b0;
    logic                          s_tlast = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [sfh_pkg::HashW-1:0]     m_tdata;

    msg_item_t                     pending_items[$];
    logic [sfh_pkg::HashW-1:0]     expected_hashes[$];
    logic [sfh_pkg::HashW-1:0]     run_hash = '0;
    int unsigned                   mismatches = 0;
    int unsigned                   items_sent = 0;
    int unsigned                   hashes_seen = 0;
    int unsigned                   hold_left = 0;
    bit                            hold_done = 1'b0;
    int unsigned                   idle_cycles = 0;
    msg_item_t                     drive_item;

    superfasthash_stream dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // one mixing round over both 16-bit halves of a word
    function automatic logic [sfh_pkg::HashW-1:0] mix_round(
        input logic [sfh_pkg::HashW-1:0] h_in,
        input logic [sfh_pkg::WordW-1:0] w);
        logic [sfh_pkg::HashW-1:0] h;
        logic [sfh_pkg::HashW-1:0] tmp;
        h = h_in + {16'd0, w[15:0]};
        tmp = ({16'd0, w[31:16]} << 11) ^ h;
        h = (h << 16) ^ tmp;
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic logic [sfh_pkg::HashW-1:0] avalanche_mix(
        input logic [sfh_pkg::HashW-1:0] h_in);
        logic [sfh_pkg::HashW-1:0] h;
        h = h_in;
        h ^= h << 3;
        h += h >> 5;
        h ^= h << 4;
        h += h >> 17;
        h ^= h << 25;
        h += h >> 6;
        return h;
    endfunction

    // advance the running hash by one accepted item, queue a hash on a last item
    task automatic predict_hash(input stream_fields_t f, input bit first, input bit last);
        logic [sfh_pkg::HashW-1:0] h;
        logic [sfh_pkg::VbW-1:0]   nb;
        if (first) begin
            run_hash = (f.seed != '0) ? f.seed : {1'b0, f.length};
        end
        h = run_hash;
        if (!last) begin
            run_hash = mix_round(h, f.word);
            return;
        end
        nb = (f.nbytes > sfh_pkg::VbFull) ? sfh_pkg::VbFull : f.nbytes;
        if (first && f.nbytes == sfh_pkg::VbNone) begin
            h = '0;
        end else begin
            case (nb)
                sfh_pkg::VbFull: begin
                    h = mix_round(h, f.word);
                end
                sfh_pkg::VbTail3: begin
                    h += {16'd0, f.word[15:0]};
                    h ^= h << 16;
                    h ^= {{24{f.word[23]}}, f.word[23:16]} << 18;
                    h += h >> 11;
                end
                sfh_pkg::VbTail2: begin
                    h += {16'd0, f.word[15:0]};
                    h ^= h << 11;
                    h += h >> 17;
                end
                sfh_pkg::VbTail1: begin
                    // lone tail byte is sign-extended
                    h += {{24{f.word[7]}}, f.word[7:0]};
                    h ^= h << 10;
                    h += h >> 1;
                end
                default: begin
                end
            endcase
            h = avalanche_mix(h);
        end
        expected_hashes = {expected_hashes, h};
        run_hash = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [sfh_pkg::HashW-1:0] got,
                                   input logic [sfh_pkg::HashW-1:0] want);
        $display("mismatch: %s got %h want %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic queue_item(input bit first, input bit last,
                              input logic [sfh_pkg::VbW-1:0] nb,
                              input logic [sfh_pkg::WordW-1:0] w,
                              input logic [sfh_pkg::LenW-1:0] len,
                              input logic [sfh_pkg::HashW-1:0] sd);
        msg_item_t it;
        it.fields = '{pad: '0, seed: sd, length: len, nbytes: nb, word: w};
        it.first = first;
        it.last = last;
        pending_items = {pending_items, it};
    endtask

    // driver: offers items, idles about a quarter of the time except in one burst
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                items_sent++;
            end
            if (pending_items.size() > 0 &&
                ((items_sent >= 300 && items_sent < 450) || $urandom_range(0, 99) >= 25)) begin
                drive_item = pending_items.pop_front();
                s_tdata <= drive_item.fields;
                s_tuser <= drive_item.first;
                s_tlast <= drive_item.last;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, one long hold-off, one stretch always ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && hashes_seen == 30) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hashes_seen >= 60 && hashes_seen < 100) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 25);
        end
    end

    // monitor: predict on accepted input items, compare accepted hashes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_hash(stream_fields_t'(s_tdata), s_tuser, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                hashes_seen <= hashes_seen + 1;
                if (expected_hashes.size() == 0) begin
                    report_mismatch("unexpected hash", m_tdata, '0);
                end else begin
                    if (m_tdata !== expected_hashes[0]) begin
                        report_mismatch("hash", m_tdata, expected_hashes[0]);
                    end
                    void'(expected_hashes.pop_front());
                end
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus and end of run
    initial begin
        int unsigned               nwords;
        logic [sfh_pkg::VbW-1:0]   tail_nb;
        logic [sfh_pkg::HashW-1:0] msg_seed;
        logic [sfh_pkg::LenW-1:0]  msg_len;
        int unsigned               r;

        // stray item right after reset, continues from zero
        queue_item(1'b0, 1'b1, sfh_pkg::VbFull, 32'hFFFF_FFFF, '0, '0);
        // empty message gives zero whatever seed and length hold
        queue_item(1'b1, 1'b1, sfh_pkg::VbNone, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        // one-byte tails, negative and positive byte
        queue_item(1'b1, 1'b1, sfh_pkg::VbTail1, 32'h0000_0080, 31'd1, '0);
        queue_item(1'b1, 1'b1, sfh_pkg::VbTail1, 32'hFFFF_FF7F, 31'd1, '0);
        // two-byte tail starting from a zero length
        queue_item(1'b1, 1'b1, sfh_pkg::VbTail2, 32'h0000_FFFF, '0, '0);
        // three-byte tails, third byte negative and positive
        queue_item(1'b1, 1'b1, sfh_pkg::VbTail3, 32'hFF80_FFFF, 31'd3, 32'd1);
        queue_item(1'b1, 1'b1, sfh_pkg::VbTail3, 32'h007F_1234, 31'd3, '0);
        // oversized counts behave as a full word
        queue_item(1'b1, 1'b1, VbOverMax, 32'hDEAD_BEEF, 31'd4, 32'hFFFF_FFFF);
        queue_item(1'b1, 1'b1, VbOverMin, 32'h1234_5678, 31'h7FFF_FFFF, '0);
        queue_item(1'b1, 1'b1, VbOverMin + 3'd1, 32'h8000_0001, 31'd4, 32'h8000_0000);
        // two full words then an empty last item
        queue_item(1'b1, 1'b0, sfh_pkg::VbNone, '0, 31'h7FFF_FFFF, '0);
        queue_item(1'b0, 1'b0, VbOverMax, 32'hFFFF_FFFF, '0, '0);
        queue_item(1'b0, 1'b1, sfh_pkg::VbNone, 32'hFFFF_FFFF, '0, '0);
        // restart while a message is open
        queue_item(1'b1, 1'b0, sfh_pkg::VbFull, 32'hCAFE_F00D, 31'd12, 32'd12345);
        queue_item(1'b1, 1'b0, sfh_pkg::VbFull, 32'h0BAD_C0DE, 31'd9, '0);
        queue_item(1'b0, 1'b0, sfh_pkg::VbFull, 32'h5555_AAAA, '0, '0);
        queue_item(1'b0, 1'b1, sfh_pkg::VbTail1, 32'h0000_00FF, '0, '0);
        // stray items after a result
        queue_item(1'b0, 1'b0, sfh_pkg::VbFull, 32'h1234_5678, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_item(1'b0, 1'b1, sfh_pkg::VbTail2, 32'hABCD_8001, '0, '0);
        // all zero single word
        queue_item(1'b1, 1'b1, sfh_pkg::VbFull, '0, '0, '0);

        // random part: mostly well-formed messages, some loose items
        while (pending_items.size() < ITEM_COUNT) begin
            if ($urandom_range(0, 99) < 85) begin
                nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24)
                                                    : $urandom_range(0, 6);
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    tail_nb = sfh_pkg::VbNone;
                end else if (r == 1) begin
                    tail_nb = sfh_pkg::VbW'($urandom_range(VbOverMin, VbOverMax));
                end else begin
                    tail_nb = sfh_pkg::VbW'($urandom_range(sfh_pkg::VbTail1,
                                                           sfh_pkg::VbFull));
                end
                msg_seed = $urandom_range(0, 1) ? $urandom : '0;
                msg_len = ($urandom_range(0, 3) == 0) ? sfh_pkg::LenW'($urandom)
                                                      : sfh_pkg::LenW'(nwords * 4 + tail_nb);
                queue_item(1'b1, nwords == 0,
                           (nwords == 0) ? tail_nb : sfh_pkg::VbW'($urandom),
                           $urandom, msg_len, msg_seed);
                for (int unsigned i = 1; i <= nwords; i++) begin
                    queue_item(1'b0, i == nwords,
                               (i == nwords) ? tail_nb : sfh_pkg::VbW'($urandom),
                               $urandom, sfh_pkg::LenW'($urandom), $urandom);
                end
            end else begin
                queue_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           sfh_pkg::VbW'($urandom), $urandom,
                           sfh_pkg::LenW'($urandom), $urandom);
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_items.size() == 0 && !s_tvalid && expected_hashes.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_hashes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* superfasthash_stream.f */
rtl/sfh_pkg.sv
rtl/sfh_front.sv
rtl/sfh_queue.sv
rtl/sfh_back.sv
rtl/superfasthash_stream.sv
rtl/sfh_checker.sv
sim/testbench.sv
